@@ sv/integer_to_ascii_formatter_unit_defines.svh @@
// assertion macros for the formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define ITOAF_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("itoaf assertion failed");

// condition in one cycle implies another in the next cycle
`define ITOAF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("itoaf assertion failed");

`else

`define ITOAF_ASSERT(label, prop)
`define ITOAF_ASSERT_NEXT(label, pre, post)

`endif

`endif

@@ sv/itoaf_pkg.sv @@
package itoaf_pkg;

    localparam int PTR_WIDTH  = 64;
    localparam int PTR_DIGITS = (PTR_WIDTH + 3) / 4;
    localparam int PTR_SHIFT  = 64 - 4 * PTR_DIGITS;
    localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - PTR_WIDTH);

    // request op codes
    localparam logic [2:0] OP_CHAR = 3'd0;
    localparam logic [2:0] OP_SDEC = 3'd1;
    localparam logic [2:0] OP_UDEC = 3'd2;
    localparam logic [2:0] OP_HEXL = 3'd3;
    localparam logic [2:0] OP_HEXU = 3'd4;
    localparam logic [2:0] OP_PTR  = 3'd5;

    typedef logic [4:0] t_pc;

    // microprogram entry points
    localparam t_pc STEP_FETCH    = 5'd0;
    localparam t_pc STEP_DISPATCH = 5'd1;
    localparam t_pc STEP_CHAR     = 5'd2;
    localparam t_pc STEP_SDEC     = 5'd3;
    localparam t_pc STEP_MINUS    = 5'd4;
    localparam t_pc STEP_UDEC     = 5'd5;
    localparam t_pc STEP_DABBLE   = 5'd6;
    localparam t_pc STEP_SKIP     = 5'd7;
    localparam t_pc STEP_DIGIT    = 5'd8;
    localparam t_pc STEP_END      = 5'd9;
    localparam t_pc STEP_HEX      = 5'd10;
    localparam t_pc STEP_PTR      = 5'd11;
    localparam t_pc STEP_PTR_0    = 5'd12;
    localparam t_pc STEP_PTR_X    = 5'd13;
    localparam t_pc STEP_PTR_LOAD = 5'd14;
    localparam t_pc STEP_NIL_0    = 5'd15;
    localparam t_pc STEP_NIL_1    = 5'd16;
    localparam t_pc STEP_NIL_2    = 5'd17;
    localparam t_pc STEP_NIL_3    = 5'd18;
    localparam t_pc STEP_NIL_4    = 5'd19;

    typedef enum logic [2:0] {
        UOP_NONE,
        UOP_ACCEPT,
        UOP_LOAD_DEC,
        UOP_DABBLE,
        UOP_SKIP0,
        UOP_EMIT,
        UOP_LOAD_HEX,
        UOP_LOAD_PTR
    } t_uop;

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DISPATCH,
        COND_NOT_NEG,
        COND_BITS_LEFT,
        COND_LEAD_ZERO,
        COND_DIGITS_LEFT,
        COND_PTR_ZERO
    } t_cond;

    typedef enum logic [1:0] {
        SEL_LIT,
        SEL_RAW,
        SEL_DIGIT
    } t_sel;

    typedef struct packed {
        t_uop       uop;
        t_cond      cond;
        t_pc        target;
        t_sel       sel;
        logic [7:0] lit;
        logic       last;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_uop       uop;
        t_sel       sel;
        logic [7:0] lit;
        logic       last;
        logic       go;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic       accept;
        logic [2:0] op;
        logic       is_neg;
        logic       bits_left;
        logic       lead_zero;
        logic       digits_left;
        logic       ptr_zero;
        logic       out_free;
    } t_stat;

endpackage

@@ sv/itoaf_if.sv @@
interface itoaf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface itoaf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

@@ sv/itoaf_seq.sv @@
module itoaf_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  itoaf_pkg::t_stat i_stat,
    output itoaf_pkg::t_ctrl o_ctrl
);
    import itoaf_pkg::*;

    function automatic t_uword uw(t_uop u, t_cond c, t_pc t, t_sel s,
                                  logic [7:0] l, logic lst);
        t_uword w;
        w.uop    = u;
        w.cond   = c;
        w.target = t;
        w.sel    = s;
        w.lit    = l;
        w.last   = lst;
        return w;
    endfunction

    // control store
    function automatic t_uword rom(t_pc a);
        t_uword w;
        case (a)
            STEP_FETCH:    w = uw(UOP_ACCEPT, COND_NO_INPUT, STEP_FETCH, SEL_LIT, 8'h00, 1'b0);
            STEP_DISPATCH: w = uw(UOP_NONE, COND_DISPATCH, STEP_FETCH, SEL_LIT, 8'h00, 1'b0);
            STEP_CHAR:     w = uw(UOP_EMIT, COND_ALWAYS, STEP_FETCH, SEL_RAW, 8'h00, 1'b1);
            STEP_SDEC:     w = uw(UOP_NONE, COND_NOT_NEG, STEP_UDEC, SEL_LIT, 8'h00, 1'b0);
            STEP_MINUS:    w = uw(UOP_EMIT, COND_NEXT, STEP_FETCH, SEL_LIT, 8'h2d, 1'b0);
            STEP_UDEC:     w = uw(UOP_LOAD_DEC, COND_NEXT, STEP_FETCH, SEL_LIT, 8'h00, 1'b0);
            STEP_DABBLE:   w = uw(UOP_DABBLE, COND_BITS_LEFT, STEP_DABBLE, SEL_LIT, 8'h00, 1'b0);
            STEP_SKIP:     w = uw(UOP_SKIP0, COND_LEAD_ZERO, STEP_SKIP, SEL_LIT, 8'h00, 1'b0);
            STEP_DIGIT:    w = uw(UOP_EMIT, COND_DIGITS_LEFT, STEP_DIGIT, SEL_DIGIT, 8'h00, 1'b0);
            STEP_END:      w = uw(UOP_NONE, COND_ALWAYS, STEP_FETCH, SEL_LIT, 8'h00, 1'b0);
            STEP_HEX:      w = uw(UOP_LOAD_HEX, COND_ALWAYS, STEP_SKIP, SEL_LIT, 8'h00, 1'b0);
            STEP_PTR:      w = uw(UOP_NONE, COND_PTR_ZERO, STEP_NIL_0, SEL_LIT, 8'h00, 1'b0);
            STEP_PTR_0:    w = uw(UOP_EMIT, COND_NEXT, STEP_FETCH, SEL_LIT, 8'h30, 1'b0);
            STEP_PTR_X:    w = uw(UOP_EMIT, COND_NEXT, STEP_FETCH, SEL_LIT, 8'h78, 1'b0);
            STEP_PTR_LOAD: w = uw(UOP_LOAD_PTR, COND_ALWAYS, STEP_SKIP, SEL_LIT, 8'h00, 1'b0);
            STEP_NIL_0:    w = uw(UOP_EMIT, COND_NEXT, STEP_FETCH, SEL_LIT, 8'h28, 1'b0);
            STEP_NIL_1:    w = uw(UOP_EMIT, COND_NEXT, STEP_FETCH, SEL_LIT, 8'h6e, 1'b0);
            STEP_NIL_2:    w = uw(UOP_EMIT, COND_NEXT, STEP_FETCH, SEL_LIT, 8'h69, 1'b0);
            STEP_NIL_3:    w = uw(UOP_EMIT, COND_NEXT, STEP_FETCH, SEL_LIT, 8'h6c, 1'b0);
            STEP_NIL_4:    w = uw(UOP_EMIT, COND_ALWAYS, STEP_FETCH, SEL_LIT, 8'h29, 1'b1);
            default:       w = uw(UOP_NONE, COND_ALWAYS, STEP_FETCH, SEL_LIT, 8'h00, 1'b0);
        endcase
        return w;
    endfunction

    function automatic t_pc dispatch(logic [2:0] op);
        t_pc p;
        case (op)
            OP_CHAR:          p = STEP_CHAR;
            OP_SDEC:          p = STEP_SDEC;
            OP_UDEC:          p = STEP_UDEC;
            OP_HEXL, OP_HEXU: p = STEP_HEX;
            OP_PTR:           p = STEP_PTR;
            default:          p = STEP_FETCH;
        endcase
        return p;
    endfunction

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w;
    logic   go;
    t_pc    pc_inc;

    assign w      = rom(r_pc);
    assign pc_inc = r_pc + 5'd1;
    // a character step waits for room in the output register
    assign go     = (w.uop != UOP_EMIT) || i_stat.out_free;

    always_comb begin
        n_pc = r_pc;
        if (go) begin
            case (w.cond)
                COND_NEXT:        n_pc = pc_inc;
                COND_ALWAYS:      n_pc = w.target;
                COND_NO_INPUT:    n_pc = i_stat.accept ? pc_inc : w.target;
                COND_DISPATCH:    n_pc = dispatch(i_stat.op);
                COND_NOT_NEG:     n_pc = i_stat.is_neg ? pc_inc : w.target;
                COND_BITS_LEFT:   n_pc = i_stat.bits_left ? w.target : pc_inc;
                COND_LEAD_ZERO:   n_pc = i_stat.lead_zero ? w.target : pc_inc;
                COND_DIGITS_LEFT: n_pc = i_stat.digits_left ? w.target : pc_inc;
                COND_PTR_ZERO:    n_pc = i_stat.ptr_zero ? w.target : pc_inc;
                default:          n_pc = STEP_FETCH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.uop  = w.uop;
    assign o_ctrl.sel  = w.sel;
    assign o_ctrl.lit  = w.lit;
    assign o_ctrl.last = w.last;
    assign o_ctrl.go   = go;

endmodule

@@ sv/itoaf_dp.sv @@
module itoaf_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    itoaf_in_if.sink         i_req,
    itoaf_out_if.source      o_txt,
    input  itoaf_pkg::t_ctrl i_ctrl,
    output itoaf_pkg::t_stat o_stat
);
    import itoaf_pkg::*;

    logic [2:0]  r_op;
    logic [63:0] r_val;
    logic [63:0] r_num;     // digits left aligned, next digit in the top nibble
    logic [31:0] r_bin;
    logic [4:0]  r_bits;
    logic [4:0]  r_ndig;
    logic        r_out_valid;
    logic [7:0]  r_ch;
    logic        r_last;

    logic        accept;
    logic        out_free;
    logic        step;
    logic [3:0]  top;
    logic        lead_zero;
    logic [31:0] mag;
    logic [63:0] ptr;
    logic [39:0] bcd_adj;
    logic [7:0]  digit_ch;
    logic [7:0]  ch_sel;
    logic        last_sel;

    assign i_req.ready = (i_ctrl.uop == UOP_ACCEPT);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_txt.ready;
    assign step        = i_ctrl.go;

    assign top       = r_num[63:60];
    assign lead_zero = (top == 4'd0) && (r_ndig > 5'd1);
    assign mag       = ((r_op == OP_SDEC) && r_val[31]) ? 32'd0 - r_val[31:0] : r_val[31:0];
    assign ptr       = r_val & PTR_MASK;

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            bcd_adj[4*i +: 4] = (r_num[24 + 4*i +: 4] >= 4'd5) ?
                                r_num[24 + 4*i +: 4] + 4'd3 : r_num[24 + 4*i +: 4];
        end
    end

    always_comb begin
        if (top < 4'd10) begin
            digit_ch = 8'h30 + {4'd0, top};
        end else if (r_op == OP_HEXU) begin
            digit_ch = 8'h37 + {4'd0, top};
        end else begin
            digit_ch = 8'h57 + {4'd0, top};
        end
    end

    always_comb begin
        case (i_ctrl.sel)
            SEL_RAW: begin
                ch_sel   = r_val[7:0];
                last_sel = i_ctrl.last;
            end
            SEL_DIGIT: begin
                ch_sel   = digit_ch;
                last_sel = (r_ndig == 5'd1);
            end
            default: begin
                ch_sel   = i_ctrl.lit;
                last_sel = i_ctrl.last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.op;
            r_val <= i_req.value;
        end
        if (step) begin
            case (i_ctrl.uop)
                UOP_LOAD_DEC: begin
                    r_num  <= '0;
                    r_bin  <= mag;
                    r_bits <= 5'd31;
                    r_ndig <= 5'd10;
                end
                UOP_DABBLE: begin
                    r_num  <= {bcd_adj[38:0], r_bin[31], 24'd0};
                    r_bin  <= {r_bin[30:0], 1'b0};
                    r_bits <= r_bits - 5'd1;
                end
                UOP_LOAD_HEX: begin
                    r_num  <= {r_val[31:0], 32'd0};
                    r_ndig <= 5'd8;
                end
                UOP_LOAD_PTR: begin
                    r_num  <= ptr << PTR_SHIFT;
                    r_ndig <= 5'(PTR_DIGITS);
                end
                UOP_SKIP0: begin
                    if (lead_zero) begin
                        r_num  <= {r_num[59:0], 4'd0};
                        r_ndig <= r_ndig - 5'd1;
                    end
                end
                UOP_EMIT: begin
                    r_ch   <= ch_sel;
                    r_last <= last_sel;
                    if (i_ctrl.sel == SEL_DIGIT) begin
                        r_num  <= {r_num[59:0], 4'd0};
                        r_ndig <= r_ndig - 5'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && (i_ctrl.uop == UOP_EMIT)) begin
            r_out_valid <= 1'b1;
        end else if (o_txt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_txt.valid = r_out_valid;
    assign o_txt.ch    = r_ch;
    assign o_txt.last  = r_last;

    assign o_stat.accept      = accept;
    assign o_stat.op          = r_op;
    assign o_stat.is_neg      = r_val[31];
    assign o_stat.bits_left   = (r_bits != 5'd0);
    assign o_stat.lead_zero   = lead_zero;
    assign o_stat.digits_left = (r_ndig > 5'd1);
    assign o_stat.ptr_zero    = (ptr == 64'd0);
    assign o_stat.out_free    = out_free;

endmodule

@@ sv/integer_to_ascii_formatter_unit.sv @@
// channel   dir   transfer when          payload
// i_req     in    valid && ready         op[2:0], value[63:0]
// o_txt     out   valid && ready         ch[7:0], last
//
// one request at a time, run by a microprogram; request taken in the fetch step
// char: one character; hex: digits; pointer: "0x" and digits, or "(nil)" when zero
// decimal: unsigned, or signed with a leading minus; converted by a double-dabble loop over 32 bits
// each character step waits while the output register holds an untaken character
// reset (synchronous, active low) returns the sequencer to fetch and drops o_txt.valid
`include "integer_to_ascii_formatter_unit_defines.svh"

module integer_to_ascii_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itoaf_in_if.sink    i_req,
    itoaf_out_if.source o_txt
);
    import itoaf_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    itoaf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    itoaf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_txt   (o_txt),
        .i_ctrl  (ctrl),
        .o_stat  (stat)
    );

    // a taken request goes to dispatch, not straight to output or another fetch
    `ITOAF_ASSERT_NEXT(a_accept_dispatch, i_req.valid && i_req.ready,
                       !i_req.ready && (ctrl.uop == UOP_NONE))

    // output only becomes valid from an executed character step
    `ITOAF_ASSERT(a_valid_from_emit,
                  $rose(o_txt.valid) |-> $past(ctrl.go && (ctrl.uop == UOP_EMIT)))

    // a stalled character holds until its transfer
    `ITOAF_ASSERT_NEXT(a_txt_hold, o_txt.valid && !o_txt.ready,
                       o_txt.valid && $stable(o_txt.ch) && $stable(o_txt.last))

endmodule
